/* rtl/randomized_queue_engine_core_defines.svh */
// Assertion macros shared by the randomized queue engine RTL.
// Included by the controller and datapath files; no other dependencies.
`ifndef RANDOMIZED_QUEUE_ENGINE_CORE_DEFINES_SVH
`define RANDOMIZED_QUEUE_ENGINE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check that a property holds at every rising clock edge outside reset.
`define RQE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rqe assertion failed");
// Check that a condition never holds outside reset.
`define RQE_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("rqe forbidden condition seen");
`else
`define RQE_ASSERT(label, clk, rst_n, prop)
`define RQE_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

/* rtl/rqe_pkg.sv */
// Shared types and codes for the randomized queue engine.
// Used by the controller, the datapath and the top level; no dependencies.
package rqe_pkg;

    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    // Request kinds; the fourth code is ignored
    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_SAMPLE  = 2'd2
    } op_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        RS_OK    = 2'd0,
        RS_FULL  = 2'd1,
        RS_EMPTY = 2'd2
    } rsp_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_req;
        logic set_status;
        rsp_t status_code;
        logic div_start;
        logic div_step;
        logic mem_enq;
        logic mem_rd_slot;
        logic capture_result;
        logic mem_rd_last;
        logic mem_move;
        logic load_out;
    } rqe_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        op_t  opcode;
        logic full;
        logic empty;
        logic div_last;
        logic out_free;
    } rqe_stat_t;

endpackage

/* rtl/randomized_queue_engine_core.sv */
// Randomized queue engine: one request in, one result out per item, one at a time.
// Enqueue writes the entry store; a request to a full or empty queue only sets the
// status, an ignored request answers OK, and dequeue and sample run the bit-serial remainder unit.
// The next item is not accepted until the result is loaded into the output register;
// a stalled output holds the next result and the input with it.
// Reset clears the count and handshake state; the entry store is not cleared.
module randomized_queue_engine_core
    import rqe_pkg::*;
#(
    parameter int QUEUE_DEPTH  = 16,
    parameter int ITEM_WIDTH   = 32,
    parameter int RANDOM_WIDTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // item_in, random_word, zero padding
    input  logic [((ITEM_WIDTH+RANDOM_WIDTH+7)/8)*8-1:0]          s_tdata,
    // opcode
    input  logic [OP_W-1:0]       s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // item_out, count, zero padding
    output logic [((ITEM_WIDTH+$clog2(QUEUE_DEPTH+1)+7)/8)*8-1:0] m_tdata,
    // status
    output logic [STATUS_W-1:0]   m_tuser
);

    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_W = ((ITEM_WIDTH + CW + 7) / 8) * 8;

    rqe_cmd_t              cmd;
    rqe_stat_t             stat;
    rsp_t                  status;
    logic [ITEM_WIDTH-1:0] item_out;
    logic [CW-1:0]         count;

    rqe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rqe_datapath #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .ITEM_WIDTH   (ITEM_WIDTH),
        .RANDOM_WIDTH (RANDOM_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .opcode      (op_t'(s_tuser)),
        .item_in     (s_tdata[ITEM_WIDTH-1:0]),
        .random_word (s_tdata[ITEM_WIDTH +: RANDOM_WIDTH]),
        .cmd         (cmd),
        .stat        (stat),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .status      (status),
        .item_out    (item_out),
        .count       (count)
    );

    // Pack the result item
    assign m_tdata = OUT_W'({count, item_out});
    assign m_tuser = status;

endmodule

/* rtl/rqe_ctrl.sv */
// Sequencing state machine of the randomized queue engine.
// Depends on rqe_pkg and the assertion macros header.
`include "randomized_queue_engine_core_defines.svh"

module rqe_ctrl
    import rqe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  rqe_stat_t stat,
    output rqe_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ENQ,
        S_DIV,
        S_RD_SLOT,
        S_RD_LAST,
        S_MOVE,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;

    assign s_tready = ready_reg;

    // Decode commands and pick the next state
    always_comb
    begin
        cmd        = '0;
        cmd.status_code = RS_OK;
        state_next = state_reg;
        ready_next = ready_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && ready_reg)
                begin
                    cmd.load_req = 1'b1;
                    ready_next   = 1'b0;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.opcode)
                    OP_ENQUEUE:
                    begin
                        if (stat.full)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = RS_FULL;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            state_next = S_ENQ;
                        end
                    end
                    OP_DEQUEUE, OP_SAMPLE:
                    begin
                        if (stat.empty)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = RS_EMPTY;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = S_DIV;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_ENQ:
            begin
                cmd.mem_enq = 1'b1;
                state_next  = S_RESP;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_RD_SLOT;
                end
            end
            S_RD_SLOT:
            begin
                cmd.mem_rd_slot = 1'b1;
                state_next      = S_RD_LAST;
            end
            S_RD_LAST:
            begin
                cmd.capture_result = 1'b1;
                if (stat.opcode == OP_DEQUEUE)
                begin
                    cmd.mem_rd_last = 1'b1;
                    state_next      = S_MOVE;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_MOVE:
            begin
                cmd.mem_move = 1'b1;
                state_next   = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    ready_next   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                ready_next = 1'b1;
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the ready flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    `RQE_ASSERT(a_out_load_free, clk, rst_n, cmd.load_out |-> stat.out_free)
    `RQE_ASSERT(a_accept_decode, clk, rst_n, (s_tvalid && s_tready) |=> state_reg == S_DECODE)
    `RQE_ASSERT(a_move_after_read, clk, rst_n, (state_reg == S_MOVE) |-> $past(state_reg == S_RD_LAST))

endmodule

/* rtl/rqe_datapath.sv */
// Datapath of the randomized queue engine: request registers, entry store,
// bit-serial remainder unit, fill count and output register.
// Depends on rqe_pkg and the assertion macros header.
`include "randomized_queue_engine_core_defines.svh"

module rqe_datapath
    import rqe_pkg::*;
#(
    parameter int QUEUE_DEPTH  = 16,
    parameter int ITEM_WIDTH   = 32,
    parameter int RANDOM_WIDTH = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  op_t                              opcode,
    input  logic [ITEM_WIDTH-1:0]            item_in,
    input  logic [RANDOM_WIDTH-1:0]          random_word,
    input  rqe_cmd_t                         cmd,
    output rqe_stat_t                        stat,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output rsp_t                             status,
    output logic [ITEM_WIDTH-1:0]            item_out,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);

    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int AW     = $clog2(QUEUE_DEPTH);
    localparam int RIDX_W = $clog2(RANDOM_WIDTH);

    logic [ITEM_WIDTH-1:0]   mem [QUEUE_DEPTH];

    op_t                     opcode_reg;
    logic [ITEM_WIDTH-1:0]   item_reg;
    logic [RANDOM_WIDTH-1:0] rnd_reg;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           rem_reg;
    logic [CW-1:0]           rem_next;
    logic [RIDX_W-1:0]       div_cnt_reg;
    rsp_t                    status_reg;
    logic [ITEM_WIDTH-1:0]   result_reg;
    logic [ITEM_WIDTH-1:0]   rd_data_reg;
    logic                    out_valid_reg;
    rsp_t                    out_status_reg;
    logic [ITEM_WIDTH-1:0]   out_item_reg;
    logic [CW-1:0]           out_count_reg;

    logic [CW:0]             trial;
    logic [CW-1:0]           trial_sub;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [ITEM_WIDTH-1:0]   wr_data;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           slot_addr;
    logic [AW-1:0]           last_addr;

    // Status toward the controller
    assign stat.opcode   = opcode_reg;
    assign stat.full     = (count_reg == CW'(QUEUE_DEPTH));
    assign stat.empty    = (count_reg == '0);
    assign stat.div_last = (div_cnt_reg == '0);
    assign stat.out_free = !out_valid_reg || m_tready;

    // One restoring remainder step: shift in the next random bit
    assign trial     = {rem_reg, rnd_reg[div_cnt_reg]};
    assign trial_sub = trial[CW-1:0] - count_reg;
    assign rem_next  = (trial >= {1'b0, count_reg}) ? trial_sub : trial[CW-1:0];

    assign slot_addr = rem_reg[AW-1:0];
    assign last_addr = AW'(count_reg - CW'(1));

    // Store port selection: enqueue at the count, move last entry into the slot
    always_comb
    begin
        wr_en   = cmd.mem_enq || cmd.mem_move;
        wr_addr = cmd.mem_enq ? count_reg[AW-1:0] : slot_addr;
        wr_data = cmd.mem_enq ? item_reg : rd_data_reg;
        rd_en   = cmd.mem_rd_slot || cmd.mem_rd_last;
        rd_addr = cmd.mem_rd_last ? last_addr : slot_addr;
    end

    // Entry store with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Latch the request and hold the working values
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            item_reg   <= item_in;
            rnd_reg    <= random_word;
            result_reg <= '0;
        end
        else if (cmd.capture_result)
        begin
            result_reg <= rd_data_reg;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= status_reg;
            out_item_reg   <= result_reg;
            out_count_reg  <= count_reg;
        end
    end

    // Control state: opcode, count, remainder, status and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opcode_reg    <= OP_ENQUEUE;
            count_reg     <= '0;
            rem_reg       <= '0;
            div_cnt_reg   <= '0;
            status_reg    <= RS_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_req)
            begin
                opcode_reg <= opcode;
                status_reg <= RS_OK;
            end
            else if (cmd.set_status)
            begin
                status_reg <= cmd.status_code;
            end
            if (cmd.mem_enq)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.mem_move)
            begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.div_start)
            begin
                rem_reg     <= '0;
                div_cnt_reg <= RIDX_W'(RANDOM_WIDTH - 1);
            end
            else if (cmd.div_step)
            begin
                rem_reg     <= rem_next;
                div_cnt_reg <= div_cnt_reg - RIDX_W'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign status   = out_status_reg;
    assign item_out = out_item_reg;
    assign count    = out_count_reg;

    `RQE_ASSERT_NEVER(a_count_range, clk, rst_n, count_reg > CW'(QUEUE_DEPTH))
    `RQE_ASSERT(a_slot_in_range, clk, rst_n, cmd.mem_rd_slot |-> rem_reg < count_reg)
    `RQE_ASSERT(a_enq_count, clk, rst_n, cmd.mem_enq |=> count_reg == $past(count_reg) + CW'(1))

endmodule
